[hdl/fzs_pkg.sv]
// ----------------------------------------------------------------------------
// fzs_pkg
// Shared types and constants of the feature z-score standardizer.
// ----------------------------------------------------------------------------
package fzs_pkg;

    localparam int FEATURES = 1024;
    localparam int FEAT_AW  = 10;

    localparam logic [1:0] MODE_ACC  = 2'd0;
    localparam logic [1:0] MODE_FIN  = 2'd1;
    localparam logic [1:0] MODE_NORM = 2'd2;
    localparam logic [1:0] MODE_READ = 2'd3;

    localparam logic [0:0] REG_COUNT  = 1'b0;
    localparam logic [0:0] REG_THRESH = 1'b1;

    localparam logic [15:0] COUNT_RESET  = 16'd60000;
    localparam logic [15:0] THRESH_RESET = 16'd0;

    typedef struct packed {
        logic [1:0]  mode;
        logic [9:0]  feature;
        logic [7:0]  pixel;
    } t_in;

    typedef struct packed {
        logic signed [23:0] normalized;
        logic [15:0]        mean_value;
        logic [15:0]        deviation;
        logic               passed_through;
        logic               saturated;
    } t_out;

    typedef struct packed {
        logic [23:0] sum;
        logic [31:0] sq;
        logic [15:0] mean;
        logic [15:0] dev;
    } t_entry;

endpackage

[hdl/fzs_ram.sv]
// ----------------------------------------------------------------------------
// fzs_ram
// Single-port-write, registered-read memory holding the per-feature entries.
// ----------------------------------------------------------------------------
module fzs_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 80
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[hdl/fzs_divider.sv]
// ----------------------------------------------------------------------------
// fzs_divider
// Restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fzs_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quo,
    output logic [63:0] o_rem
);

    logic [63:0] r_rem;
    logic [63:0] r_quo;
    logic [63:0] r_den;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic [64:0] n_trial;
    logic [64:0] n_shift;

    always_comb begin
        n_shift = {r_rem, r_quo[63]};
        n_trial = n_shift - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= r_busy && !i_start && (r_cnt == 7'd1);
            if (i_start) begin
                r_busy <= 1'b1;
                r_rem  <= '0;
                r_quo  <= i_num;
                r_den  <= i_den;
                r_cnt  <= 7'd64;
            end else if (r_busy) begin
                if (!n_trial[64]) begin
                    r_rem <= n_trial[63:0];
                    r_quo <= {r_quo[62:0], 1'b1};
                end else begin
                    r_rem <= n_shift[63:0];
                    r_quo <= {r_quo[62:0], 1'b0};
                end
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_quo = r_quo;
    assign o_rem = r_rem;

endmodule

[hdl/fzs_sqrt.sv]
// ----------------------------------------------------------------------------
// fzs_sqrt
// Integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module fzs_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_val,
    output logic        o_done,
    output logic [31:0] o_root
);

    logic [63:0] r_v;
    logic [63:0] r_res;
    logic [63:0] r_bit;
    logic        r_busy;
    logic [63:0] n_sum;

    assign n_sum = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= r_busy && !i_start && r_bit[0];
            if (i_start) begin
                r_busy <= 1'b1;
                r_v    <= i_val;
                r_res  <= '0;
                r_bit  <= 64'h4000_0000_0000_0000;
            end else if (r_busy) begin
                if (r_v >= n_sum) begin
                    r_v   <= r_v - n_sum;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                if (r_bit[0]) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_root = r_res[31:0];

endmodule

[hdl/feature_zscore_standardizer_core.sv]
// ----------------------------------------------------------------------------
// feature_zscore_standardizer_core
// Per-feature accumulate, finalize, normalize and read with statistics in memory.
// ----------------------------------------------------------------------------
// Accumulate items and finalize items with a zero count go from start to
// result strobe through memory read, then modify and write back; read-only
// items and normalize items that pass through skip the write back. Normalize
// with a divide and finalize wait on the shared bit-serial divider, and
// finalize also on the bit-serial square root. After reset a pass with busy
// high clears all 1024 statistics entries. Results cannot be stalled.
module feature_zscore_standardizer_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  fzs_pkg::t_in        i_item,
    output logic                o_strobe,
    output fzs_pkg::t_out       o_result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    typedef enum logic [10:0] {
        S_CLEAR = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_READ  = 11'b00000000100,
        S_EXEC  = 11'b00000001000,
        S_MDIV  = 11'b00000010000,
        S_VDIV1 = 11'b00000100000,
        S_VDIV2 = 11'b00001000000,
        S_SQRT  = 11'b00010000000,
        S_NDIV  = 11'b00100000000,
        S_WB    = 11'b01000000000,
        S_MULT  = 11'b10000000000
    } t_state;

    t_state r_state;
    logic [15:0] r_count;
    logic [15:0] r_thresh;
    fzs_pkg::t_in r_item;
    fzs_pkg::t_entry r_ent;
    logic [9:0] r_clr;
    logic [63:0] r_d;
    logic [63:0] r_cc;
    logic [63:0] r_vq;
    logic r_neg;
    logic [15:0] r_mean;

    logic ram_we;
    logic [9:0] ram_waddr;
    fzs_pkg::t_entry ram_wdata;
    fzs_pkg::t_entry ram_rdata;

    logic div_start;
    logic [63:0] div_num;
    logic [63:0] div_den;
    logic div_done;
    logic [63:0] div_quo;
    logic [63:0] div_rem;
    logic sq_start;
    logic [63:0] sq_val;
    logic sq_done;
    logic [31:0] sq_root;

    logic apb_wr;
    assign pready = 1'b1;
    assign apb_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= fzs_pkg::COUNT_RESET;
            r_thresh <= fzs_pkg::THRESH_RESET;
        end else if (apb_wr) begin
            if (paddr == {fzs_pkg::REG_COUNT, 2'b00}) begin
                r_count <= pwdata[15:0];
            end else if (paddr == {fzs_pkg::REG_THRESH, 2'b00}) begin
                r_thresh <= pwdata[15:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == {fzs_pkg::REG_COUNT, 2'b00}) begin
            prdata = {16'd0, r_count};
        end else if (paddr == {fzs_pkg::REG_THRESH, 2'b00}) begin
            prdata = {16'd0, r_thresh};
        end
    end

    fzs_ram #(
        .DEPTH (fzs_pkg::FEATURES),
        .AW    (fzs_pkg::FEAT_AW),
        .DW    ($bits(fzs_pkg::t_entry))
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (i_item.feature),
        .o_rdata (ram_rdata)
    );

    fzs_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    fzs_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_val   (sq_val),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    logic [24:0] acc_s;
    logic [32:0] acc_q;
    logic [15:0] px_sq;
    logic [16:0] pxq8;
    logic signed [17:0] ndiff;
    logic [17:0] nabs;
    logic [24:0] nmag;
    logic signed [25:0] nval;

    always_comb begin
        px_sq = {8'd0, r_item.pixel} * {8'd0, r_item.pixel};
        acc_s = {1'b0, r_ent.sum} + {17'd0, r_item.pixel};
        acc_q = {1'b0, r_ent.sq} + {17'd0, px_sq};
        pxq8  = {1'b0, r_item.pixel, 8'd0};
        ndiff = $signed({1'b0, pxq8}) - $signed({2'b00, r_ent.mean});
        nabs  = ndiff[17] ? 18'(-ndiff) : 18'(ndiff);
        nmag  = div_quo[24:0];
        nval  = r_neg ? -$signed({1'b0, nmag}) : $signed({1'b0, nmag});
    end

    fzs_pkg::t_out n_result;
    logic n_strobe;

    always_comb begin
        n_result = '0;
        n_result.mean_value = r_ent.mean;
        n_result.deviation  = r_ent.dev;
        case (r_item.mode)
            fzs_pkg::MODE_ACC: begin
                n_result.saturated = acc_s[24] | acc_q[32];
            end
            fzs_pkg::MODE_FIN: begin
                if (r_count == 16'd0) begin
                    n_result.mean_value = '0;
                    n_result.deviation  = '0;
                end
            end
            fzs_pkg::MODE_NORM: begin
                if (r_ent.dev <= r_thresh) begin
                    n_result.passed_through = 1'b1;
                    n_result.normalized     = 24'(pxq8);
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_strobe = 1'b0;
        if (r_state == S_EXEC) begin
            if (r_item.mode == fzs_pkg::MODE_NORM) begin
                n_strobe = (r_ent.dev <= r_thresh);
            end else if (r_item.mode != fzs_pkg::MODE_ACC &&
                         r_item.mode != fzs_pkg::MODE_FIN) begin
                n_strobe = 1'b1;
            end
        end
        if (r_state == S_NDIV && div_done) begin
            n_strobe = 1'b1;
        end
        if (r_state == S_WB) begin
            n_strobe = 1'b1;
        end
    end

    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = {48'd0, r_count};
        sq_start  = 1'b0;
        sq_val    = r_vq;
        ram_we    = 1'b0;
        ram_waddr = r_item.feature;
        ram_wdata = r_ent;
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr;
            ram_wdata = '0;
        end
        if (r_state == S_EXEC) begin
            if (r_item.mode == fzs_pkg::MODE_FIN && r_count != 16'd0) begin
                div_start = 1'b1;
                div_num   = {32'd0, r_ent.sum, 8'd0};
            end else if (r_item.mode == fzs_pkg::MODE_NORM && r_ent.dev > r_thresh) begin
                div_start = 1'b1;
                div_num   = {38'd0, nabs, 8'd0};
                div_den   = {48'd0, r_ent.dev};
            end
        end
        if (r_state == S_MDIV && div_done) begin
            div_start = 1'b1;
            div_num   = r_d;
            div_den   = r_cc;
        end
        if (r_state == S_VDIV1 && div_done) begin
            div_start = 1'b1;
            div_num   = {div_rem[47:0], 16'd0};
            div_den   = r_cc;
        end
        if (r_state == S_VDIV2 && div_done) begin
            sq_start = 1'b1;
            sq_val   = r_vq + div_quo;
        end
        if (r_state == S_WB) begin
            ram_we = 1'b1;
        end
    end

    logic [63:0] mul_a;
    logic [63:0] mul_b;
    assign mul_a = {32'd0, r_ent.sq} * {48'd0, r_count};
    assign mul_b = {40'd0, r_ent.sum} * {40'd0, r_ent.sum};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= n_strobe;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 10'd1;
                    if (r_clr == 10'(fzs_pkg::FEATURES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_item  <= i_item;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_EXEC;
                    r_ent   <= ram_rdata;
                end
                S_EXEC: begin
                    o_result <= n_result;
                    r_neg <= ndiff[17];
                    case (r_item.mode)
                        fzs_pkg::MODE_ACC: begin
                            r_ent.sum <= acc_s[24] ? 24'hFFFFFF : acc_s[23:0];
                            r_ent.sq  <= acc_q[32] ? 32'hFFFFFFFF : acc_q[31:0];
                            r_state <= S_WB;
                        end
                        fzs_pkg::MODE_FIN: begin
                            if (r_count == 16'd0) begin
                                r_ent.mean <= '0;
                                r_ent.dev  <= '0;
                                r_state <= S_WB;
                            end else begin
                                r_state <= S_MULT;
                            end
                        end
                        fzs_pkg::MODE_NORM: begin
                            if (r_ent.dev <= r_thresh) begin
                                r_state  <= S_IDLE;
                            end else begin
                                r_state <= S_NDIV;
                            end
                        end
                        default: begin
                            r_state  <= S_IDLE;
                        end
                    endcase
                end
                S_MULT: begin
                    r_d     <= (mul_a > mul_b) ? mul_a - mul_b : 64'd0;
                    r_cc    <= {32'd0, r_count} * {48'd0, r_count};
                    r_state <= S_MDIV;
                end
                S_MDIV: begin
                    if (div_done) begin
                        if (div_quo > 64'hFFFF) begin
                            r_mean <= 16'hFFFF;
                            o_result.saturated <= 1'b1;
                        end else begin
                            r_mean <= div_quo[15:0];
                        end
                        r_state <= S_VDIV1;
                    end
                end
                S_VDIV1: begin
                    if (div_done) begin
                        r_vq    <= {div_quo[47:0], 16'd0};
                        r_state <= S_VDIV2;
                    end
                end
                S_VDIV2: begin
                    if (div_done) begin
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (sq_done) begin
                        r_ent.mean <= r_mean;
                        o_result.mean_value <= r_mean;
                        if (sq_root > 32'hFFFF) begin
                            r_ent.dev <= 16'hFFFF;
                            o_result.deviation <= 16'hFFFF;
                            o_result.saturated <= 1'b1;
                        end else begin
                            r_ent.dev <= sq_root[15:0];
                            o_result.deviation <= sq_root[15:0];
                        end
                        r_state <= S_WB;
                    end
                end
                S_NDIV: begin
                    if (div_done) begin
                        if (div_quo > 64'h7FFFFF && !r_neg) begin
                            o_result.normalized <= 24'h7FFFFF;
                            o_result.saturated  <= 1'b1;
                        end else if (div_quo > 64'h800000 && r_neg) begin
                            o_result.normalized <= 24'h800000;
                            o_result.saturated  <= 1'b1;
                        end else begin
                            o_result.normalized <= nval[23:0];
                        end
                        r_state  <= S_IDLE;
                    end
                end
                S_WB: begin
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy = (r_state != S_IDLE);

`ifndef SYNTHESIS
    a_no_strobe_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_strobe)
        else $error("strobe during clearing pass");
    a_wb_then_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WB) |=> o_strobe)
        else $error("write back without result");
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (r_state == S_IDLE))
        else $error("result while still working");
`endif

endmodule
